/* rtl/gha_pkg.sv */
// gha_pkg: shared widths, register indexes and beat types for the ghash accumulator
// no dependencies; imported by every module under rtl
package gha_pkg;

    // field and block widths
    localparam int C_HALF_W  = 64;
    localparam int C_BLOCK_W = 2 * C_HALF_W;
    localparam int C_CFG_AW  = 1;

    // gcm reduction byte, x^0 in its most significant bit
    localparam logic [7:0] C_REDUCE_BYTE = 8'hE1;

    // configuration register indexes
    localparam logic [C_CFG_AW-1:0] C_REG_SUBKEY_HIGH = 1'd0;
    localparam logic [C_CFG_AW-1:0] C_REG_SUBKEY_LOW  = 1'd1;

    // one accepted input beat, block as {bytes 0-7, bytes 8-15}
    typedef struct packed {
        logic [C_BLOCK_W-1:0] block;
        logic                 start;
        logic                 last;
    } t_in_beat;

endpackage

/* rtl/gha_gf_mult.sv */
// gha_gf_mult: combinational gf(2^128) multiply in gcm bit order
// depends on gha_pkg for widths and the reduction byte
module gha_gf_mult (
    input  logic [gha_pkg::C_BLOCK_W-1:0] i_x,
    input  logic [gha_pkg::C_BLOCK_W-1:0] i_h,
    output logic [gha_pkg::C_BLOCK_W-1:0] o_z
);
    import gha_pkg::*;

    localparam int C_PROD_W = 2 * C_BLOCK_W - 1;
    localparam int C_FOLD_W = C_BLOCK_W + 6;

    logic [C_BLOCK_W-1:0] w_a;
    logic [C_BLOCK_W-1:0] w_b;
    logic [C_PROD_W-1:0]  w_prod;
    logic [C_FOLD_W-1:0]  w_fold1;
    logic [C_BLOCK_W-1:0] w_fold2;
    logic [7:0]           w_poly;

    // word bit 127 is the x^0 coefficient, so flip to plain polynomial order
    always_comb begin
        for (int k = 0; k < C_BLOCK_W; k++) begin
            w_a[k] = i_x[C_BLOCK_W-1-k];
            w_b[k] = i_h[C_BLOCK_W-1-k];
        end
        for (int d = 0; d < 8; d++) begin
            w_poly[d] = C_REDUCE_BYTE[7-d];
        end
    end

    // carry-less product, one xor tree per product bit
    always_comb begin
        for (int k = 0; k < C_PROD_W; k++) begin
            w_prod[k] = 1'b0;
            for (int i = 0; i < C_BLOCK_W; i++) begin
                if ((k - i >= 0) && (k - i < C_BLOCK_W)) begin
                    w_prod[k] = w_prod[k] ^ (w_a[i] & w_b[k-i]);
                end
            end
        end
    end

    // first fold: x^128 = x^7 + x^2 + x + 1 applied to degrees 128..254
    always_comb begin
        w_fold1 = {6'd0, w_prod[C_BLOCK_W-1:0]};
        for (int j = 0; j < C_PROD_W - C_BLOCK_W; j++) begin
            for (int d = 0; d < 8; d++) begin
                if (w_poly[d]) begin
                    w_fold1[j+d] = w_fold1[j+d] ^ w_prod[C_BLOCK_W+j];
                end
            end
        end
    end

    // second fold for the few bits that spill past degree 127
    always_comb begin
        w_fold2 = w_fold1[C_BLOCK_W-1:0];
        for (int j = 0; j < C_FOLD_W - C_BLOCK_W; j++) begin
            for (int d = 0; d < 8; d++) begin
                if (w_poly[d]) begin
                    w_fold2[j+d] = w_fold2[j+d] ^ w_fold1[C_BLOCK_W+j];
                end
            end
        end
    end

    // back to gcm bit order
    always_comb begin
        for (int k = 0; k < C_BLOCK_W; k++) begin
            o_z[C_BLOCK_W-1-k] = w_fold2[k];
        end
    end

endmodule

/* rtl/gha_out_reg.sv */
// gha_out_reg: result register on the master side of the stream
// depends on gha_pkg for the block width
module gha_out_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [gha_pkg::C_BLOCK_W-1:0] i_data,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [gha_pkg::C_BLOCK_W-1:0] o_data,
    output logic                          o_can_load
);
    import gha_pkg::*;

    logic                 r_valid;
    logic [C_BLOCK_W-1:0] r_data;

    // room for a new result when empty or the held one leaves this cycle
    assign o_can_load = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/ghash_gf128_accumulator.sv */
// ghash_gf128_accumulator: gcm ghash engine, y = (y ^ block) * h per beat
// depends on gha_pkg, gha_gf_mult and gha_out_reg
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata block, tuser start, tlast last
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata hash
// cfg       in   i_cfg_we                      i_cfg_addr, i_cfg_wdata
//
// one block per cycle sustained while no last block is stalled; a beat is held in the input register
// and the multiply feeds the accumulator straight from it, so a last block's hash passes through the
// input register and then the output register before m_axis_tvalid rises.
// reset clears the accumulator, the subkey and both valid flags; no clearing pass.
// a last block stalls in the input register only while an earlier result waits.
module ghash_gf128_accumulator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [gha_pkg::C_CFG_AW-1:0]   i_cfg_addr,
    input  logic [gha_pkg::C_HALF_W-1:0]   i_cfg_wdata,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [gha_pkg::C_BLOCK_W-1:0]  s_axis_tdata,  // block_high[63:0], block_low[127:64]
    input  logic                           s_axis_tuser,  // start_new
    input  logic                           s_axis_tlast,  // last_block
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [gha_pkg::C_BLOCK_W-1:0]  m_axis_tdata   // hash_high[63:0], hash_low[127:64]
);
    import gha_pkg::*;

    logic [C_HALF_W-1:0]  r_subkey_high;
    logic [C_HALF_W-1:0]  r_subkey_low;
    logic [C_BLOCK_W-1:0] r_accum;
    logic                 r_in_valid;
    t_in_beat             r_in_beat;

    t_in_beat             w_beat;
    logic [C_BLOCK_W-1:0] w_mul_x;
    logic [C_BLOCK_W-1:0] w_mul_z;
    logic [C_BLOCK_W-1:0] w_hash;
    logic                 w_fire;
    logic                 w_out_can_load;

    // subkey registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subkey_high <= '0;
            r_subkey_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                C_REG_SUBKEY_HIGH: r_subkey_high <= i_cfg_wdata;
                C_REG_SUBKEY_LOW:  r_subkey_low  <= i_cfg_wdata;
            endcase
        end
    end

    // unpack the input beat, block high half in the low tdata bits
    always_comb begin
        w_beat.block = {s_axis_tdata[C_HALF_W-1:0], s_axis_tdata[C_BLOCK_W-1:C_HALF_W]};
        w_beat.start = s_axis_tuser;
        w_beat.last  = s_axis_tlast;
    end

    // held beat moves on unless it carries a result and the output is full
    assign w_fire        = r_in_valid && (!r_in_beat.last || w_out_can_load);
    assign s_axis_tready = !r_in_valid || w_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_beat <= w_beat;
        end
    end

    // absorb the block, a start beat discards the running value
    assign w_mul_x = (r_in_beat.start ? '0 : r_accum) ^ r_in_beat.block;

    gha_gf_mult u_mult (
        .i_x (w_mul_x),
        .i_h ({r_subkey_high, r_subkey_low}),
        .o_z (w_mul_z)
    );

    // accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
        end else if (w_fire) begin
            r_accum <= w_mul_z;
        end
    end

    gha_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire && r_in_beat.last),
        .i_data     (w_mul_z),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_data     (w_hash),
        .o_can_load (w_out_can_load)
    );

    // hash high half goes to the low tdata bits
    assign m_axis_tdata = {w_hash[C_HALF_W-1:0], w_hash[C_BLOCK_W-1:C_HALF_W]};

`ifndef SYNTHESIS
    // a last block that leaves the input register always shows up as a result
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_beat.last) |=> m_axis_tvalid)
        else $error("last block absorbed without a result");

    // the emitted hash is the accumulator just written
    a_result_is_accum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_beat.last) |=> (w_hash == r_accum))
        else $error("result differs from accumulator");

    // the accumulator only moves when a block is absorbed
    a_accum_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_fire && i_rst_n) |=> $stable(r_accum))
        else $error("accumulator changed without a block");

    // a stalled last block keeps the input side closed
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_beat.last && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted over a stalled last block");
`endif

endmodule
